FILE: rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared widths, character codes and sequencer states for the signed
// integer to decimal text converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

    // binary magnitude and packed bcd widths
    localparam int BIN_W    = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int ITER_W   = $clog2(BIN_W);
    localparam int CNT_W    = $clog2(DIGITS + 1);
    localparam int CHAR_W   = 6;
    localparam int TDATA_W  = 8;

    // ascii codes, sized to the character field width
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_SIGN,
        S_DIGIT
    } t_state;

endpackage

FILE: rtl/itoa_dabble.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itoa_dabble
// One step of the shift-and-add-3 binary to bcd conversion: every bcd
// digit of 5 or more gets 3 added, then bcd and binary shift left as one.
// ---------------------------------------------------------------------------
module itoa_dabble (
    input  logic [itoa_pkg::BCD_W-1:0] i_bcd,
    input  logic [itoa_pkg::BIN_W-1:0] i_bin,
    output logic [itoa_pkg::BCD_W-1:0] o_bcd,
    output logic [itoa_pkg::BIN_W-1:0] o_bin
);

    logic [itoa_pkg::BCD_W-1:0] w_adj;

    // add-3 correction on each digit
    always_comb begin
        for (int d = 0; d < itoa_pkg::DIGITS; d++) begin
            if (i_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = i_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = i_bcd[4*d +: 4];
            end
        end
    end

    // joint left shift, binary msb enters the bcd lsb
    assign o_bcd = {w_adj[itoa_pkg::BCD_W-2:0], i_bin[itoa_pkg::BIN_W-1]};
    assign o_bin = {i_bin[itoa_pkg::BIN_W-2:0], 1'b0};

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ascii text, one
// character per output item, most significant digit first.
// ---------------------------------------------------------------------------
// Each input item is one 32-bit two's complement value. The block takes its
// magnitude, converts it to ten bcd digits with a shared shift-and-add-3
// unit (one binary bit per cycle), drops leading zero digits one per cycle
// and keeps the first nonzero digit (zero keeps a single '0'), then sends
// a '-' if the value is negative followed by the digits, one per output
// item, with tlast on the final digit. The input is not ready again until
// the last character has been taken.
// -2147483648 converts exactly, giving 11 characters.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input item
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic signed [itoa_pkg::BIN_W-1:0]    i_s_tdata,   // [31:0] value
    // output item
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [itoa_pkg::TDATA_W-1:0]         o_m_tdata,   // [5:0] character
    output logic                                 o_m_tlast    // last character
);

    itoa_pkg::t_state               r_state, n_state;
    logic [itoa_pkg::BIN_W-1:0]     r_bin,   n_bin;
    logic [itoa_pkg::BCD_W-1:0]     r_bcd,   n_bcd;
    logic [itoa_pkg::ITER_W-1:0]    r_iter,  n_iter;
    logic [itoa_pkg::CNT_W-1:0]     r_cnt,   n_cnt;
    logic                           r_neg,   n_neg;

    logic [itoa_pkg::BCD_W-1:0]     w_step_bcd;
    logic [itoa_pkg::BIN_W-1:0]     w_step_bin;
    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_top_zero;
    logic [itoa_pkg::CHAR_W-1:0]    w_char;

    // shared conversion unit
    itoa_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (w_step_bcd),
        .o_bin (w_step_bin)
    );

    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = o_m_tvalid && i_m_tready;
    assign w_top_zero = (r_bcd[itoa_pkg::BCD_W-1 -: 4] == 4'd0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itoa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = itoa_pkg::S_CONV;
                end
            end
            itoa_pkg::S_CONV: begin
                if (r_iter == itoa_pkg::ITER_W'(itoa_pkg::BIN_W - 1)) begin
                    n_state = itoa_pkg::S_TRIM;
                end
            end
            itoa_pkg::S_TRIM: begin
                if (!(w_top_zero && r_cnt > itoa_pkg::CNT_W'(1))) begin
                    n_state = r_neg ? itoa_pkg::S_SIGN : itoa_pkg::S_DIGIT;
                end
            end
            itoa_pkg::S_SIGN: begin
                if (w_out_acc) begin
                    n_state = itoa_pkg::S_DIGIT;
                end
            end
            itoa_pkg::S_DIGIT: begin
                if (w_out_acc && r_cnt == itoa_pkg::CNT_W'(1)) begin
                    n_state = itoa_pkg::S_IDLE;
                end
            end
            default: n_state = itoa_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_iter = r_iter;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        unique case (r_state)
            itoa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_neg  = i_s_tdata[itoa_pkg::BIN_W-1];
                    n_bin  = i_s_tdata[itoa_pkg::BIN_W-1]
                           ? itoa_pkg::BIN_W'(~i_s_tdata + 32'sd1)
                           : itoa_pkg::BIN_W'(i_s_tdata);
                    n_bcd  = '0;
                    n_iter = '0;
                end
            end
            itoa_pkg::S_CONV: begin
                n_bin  = w_step_bin;
                n_bcd  = w_step_bcd;
                n_iter = r_iter + itoa_pkg::ITER_W'(1);
                n_cnt  = itoa_pkg::CNT_W'(itoa_pkg::DIGITS);
            end
            itoa_pkg::S_TRIM: begin
                if (w_top_zero && r_cnt > itoa_pkg::CNT_W'(1)) begin
                    n_bcd = {r_bcd[itoa_pkg::BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - itoa_pkg::CNT_W'(1);
                end
            end
            itoa_pkg::S_SIGN: begin
            end
            itoa_pkg::S_DIGIT: begin
                if (w_out_acc) begin
                    n_bcd = {r_bcd[itoa_pkg::BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - itoa_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // handshake and payload outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_m_tlast  = 1'b0;
        w_char     = itoa_pkg::CHAR_ZERO;
        unique case (r_state) inside
            itoa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            itoa_pkg::S_CONV, itoa_pkg::S_TRIM: begin
            end
            itoa_pkg::S_SIGN: begin
                o_m_tvalid = 1'b1;
                w_char     = itoa_pkg::CHAR_MINUS;
            end
            itoa_pkg::S_DIGIT: begin
                o_m_tvalid = 1'b1;
                o_m_tlast  = (r_cnt == itoa_pkg::CNT_W'(1));
                w_char     = itoa_pkg::CHAR_ZERO
                           + itoa_pkg::CHAR_W'(r_bcd[itoa_pkg::BCD_W-1 -: 4]);
            end
            default: begin
            end
        endcase
    end

    assign o_m_tdata = itoa_pkg::TDATA_W'(w_char);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_iter <= n_iter;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
    end

endmodule
